// ===== src/cdmc_pkg.sv =====
// Shared types, constants and segment/digit helper functions of the clock display controller.
package cdmc_pkg;

   // Item kinds on the request side.
   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_KEY_ONE = 2'd1,
      CMD_KEY_TWO = 2'd2,
      CMD_REFRESH = 2'd3
   } cmd_type;

   // What the result asks the clock chip to do.
   typedef enum logic [1:0] {
      WRITE_NONE  = 2'd0,
      WRITE_STORE = 2'd1,
      WRITE_RESET = 2'd2,
      WRITE_SPARE = 2'd3
   } write_kind_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_BLINK_TICKS    = 3'd0,
      CSR_SAMPLE_TICKS   = 3'd1,
      CSR_TIME_PHASE_END = 3'd2,
      CSR_TEMP_PHASE_END = 3'd3,
      CSR_CYCLE_END      = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   // Menu codes.
   localparam logic [2:0] MENU_ROTATE   = 3'd0;
   localparam logic [2:0] MENU_TIME     = 3'd1;
   localparam logic [2:0] MENU_TEMP     = 3'd2;
   localparam logic [2:0] MENU_LIGHT    = 3'd3;
   localparam logic [2:0] MENU_SET_MIN  = 3'd4;
   localparam logic [2:0] MENU_SET_HOUR = 3'd5;
   localparam logic [2:0] MENU_WRAP     = 3'd6;

   // Reset values of the configuration registers.
   localparam logic [7:0] BLINK_TICKS_RESET    = 8'd30;
   localparam logic [7:0] SAMPLE_TICKS_RESET   = 8'd20;
   localparam logic [9:0] TIME_PHASE_END_RESET = 10'd300;
   localparam logic [9:0] TEMP_PHASE_END_RESET = 10'd500;
   localparam logic [9:0] CYCLE_END_RESET      = 10'd700;

   localparam logic [13:0] TEMP_MAX   = 14'd9999;
   localparam logic [7:0]  MINUTE_TOP = 8'h59;
   localparam logic [8:0]  HOUR_LIMIT = 9'h024;
   localparam logic [3:0]  BLANK_CODE   = 4'd10;
   localparam logic [3:0]  CELSIUS_CODE = 4'd11;
   localparam logic [7:0]  SEG_OFF      = 8'hFF;

   // Reciprocal multipliers for the constant divisions, exact over the input ranges.
   localparam logic [27:0] RECIP_1000 = 28'd8389;
   localparam int          SHIFT_1000 = 23;
   localparam logic [27:0] RECIP_100  = 28'd10486;
   localparam int          SHIFT_100  = 20;
   localparam logic [27:0] RECIP_10   = 28'd6554;
   localparam int          SHIFT_10   = 16;
   localparam logic [20:0] RECIP_50   = 21'd1311;
   localparam int          SHIFT_50   = 16;
   localparam logic [6:0]  DWELL_MUL  = 7'd5;

   typedef struct packed {
      logic [7:0] blink_ticks;
      logic [7:0] sample_ticks;
      logic [9:0] time_phase_end;
      logic [9:0] temp_phase_end;
      logic [9:0] cycle_end;
   } cfg_type;

   // Controller state as the display formatter sees it.
   typedef struct packed {
      logic [2:0] menu_mode;
      logic       blink_on;
      logic       show_temp;
      logic       show_light;
      logic [7:0] held_hour;
      logic [7:0] held_minute;
   } view_type;

   typedef struct packed {
      logic [3:0] thousands;
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   typedef struct packed {
      logic [7:0] seg3;
      logic [7:0] seg2;
      logic [7:0] seg1;
      logic [7:0] seg0;
   } segs_type;

   function automatic logic [7:0] seg_up_plain(input logic [3:0] code);
      logic [7:0] s;
      unique case (code)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         4'd11:   s = 8'hC6;
         default: s = SEG_OFF;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] seg_up_point(input logic [3:0] code);
      logic [7:0] s;
      unique case (code)
         4'd0:    s = 8'h40;
         4'd1:    s = 8'h79;
         4'd2:    s = 8'h24;
         4'd3:    s = 8'h30;
         4'd4:    s = 8'h19;
         4'd5:    s = 8'h12;
         4'd6:    s = 8'h02;
         4'd7:    s = 8'h78;
         4'd8:    s = 8'h00;
         4'd9:    s = 8'h10;
         default: s = SEG_OFF;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] seg_dn_point(input logic [3:0] code);
      logic [7:0] s;
      unique case (code)
         4'd0:    s = 8'h40;
         4'd1:    s = 8'h4F;
         4'd2:    s = 8'h24;
         4'd3:    s = 8'h06;
         4'd4:    s = 8'h0B;
         4'd5:    s = 8'h12;
         4'd6:    s = 8'h10;
         4'd7:    s = 8'h47;
         4'd8:    s = 8'h00;
         4'd9:    s = 8'h02;
         default: s = SEG_OFF;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] seg_dn_plain(input logic [3:0] code);
      logic [7:0] s;
      unique case (code)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hCF;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'h86;
         4'd4:    s = 8'h8B;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h90;
         4'd7:    s = 8'hC7;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h82;
         default: s = SEG_OFF;
      endcase
      return s;
   endfunction

   // Splits a value of at most 9999 into its four decimal digits.
   function automatic digits_type split_decimal(input logic [13:0] v);
      logic [27:0] p1000;
      logic [27:0] p100;
      logic [27:0] p10;
      logic [3:0]  q1000;
      logic [6:0]  q100;
      logic [9:0]  q10;
      digits_type  d;
      p1000 = 28'(v) * RECIP_1000;
      p100  = 28'(v) * RECIP_100;
      p10   = 28'(v) * RECIP_10;
      q1000 = p1000[SHIFT_1000 +: 4];
      q100  = p100[SHIFT_100 +: 7];
      q10   = p10[SHIFT_10 +: 10];
      d.thousands = q1000;
      d.hundreds  = 4'(q100 - 7'(q1000) * 7'd10);
      d.tens      = 4'(q10 - 10'(q100) * 10'd10);
      d.units     = 4'(v - 14'(q10) * 14'd10);
      return d;
   endfunction

   // True when a refresh in this state shows the live time.
   function automatic logic time_shown(input view_type vw);
      return (vw.menu_mode == MENU_TIME) ||
             (vw.menu_mode == MENU_ROTATE && !vw.show_temp && !vw.show_light);
   endfunction

endpackage

// ===== src/clock_display_mode_controller_top.sv =====
// An accepted request item goes through the input register, then the result register, to rsp.
// Throughput: one item per cycle while rsp_tready is high; the input and result registers hold items
// while the rsp side stalls, and the controller state advances as an item enters the result register.
// Reset (synchronous, active high) empties both registers, clears menu, counters and held time
// to zero and loads the configuration registers with their default values.
module clock_display_mode_controller_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rtc_hour[7:0], rtc_minute[15:8], rtc_second[23:16], temperature[37:24], luminance[47:38]
   input  logic [47:0]                      req_tdata,
   // cmd[1:0]
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // seg_digit0[7:0], seg_digit1[15:8], seg_digit2[23:16], seg_digit3[31:24], dwell[38:32],
   // sample_request[39], write_hour[47:40], write_minute[55:48], write_second[63:56]
   output logic [63:0]                      rsp_tdata,
   // write_kind[1:0]
   output logic [1:0]                       rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cdmc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cdmc_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic               req_valid_ff, req_valid_in;
   logic [47:0]        req_data_ff;
   logic [1:0]         req_cmd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff;
   logic [1:0]         rsp_user_ff;
   logic               out_free;
   logic               step;
   logic               req_take;
   cdmc_pkg::cfg_type  cfg;
   cdmc_pkg::view_type view;
   cdmc_pkg::segs_type segs;
   logic [6:0]         dwell;
   logic               sample_request;
   logic [1:0]         write_kind;
   logic [7:0]         write_hour;
   logic [7:0]         write_minute;
   logic [7:0]         write_second;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign step         = req_valid_ff && out_free;
   assign req_tready   = !req_valid_ff || out_free;
   assign req_take     = req_tvalid && req_tready;
   assign req_valid_in = req_take || (req_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   cdmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cdmc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .cmd            (req_cmd_ff),
      .rtc_hour       (req_data_ff[7:0]),
      .rtc_minute     (req_data_ff[15:8]),
      .rtc_second     (req_data_ff[23:16]),
      .cfg            (cfg),
      .view           (view),
      .sample_request (sample_request),
      .write_kind     (write_kind),
      .write_hour     (write_hour),
      .write_minute   (write_minute),
      .write_second   (write_second)
   );

   cdmc_render u_render (
      .cmd         (req_cmd_ff),
      .rtc_hour    (req_data_ff[7:0]),
      .rtc_minute  (req_data_ff[15:8]),
      .temperature (req_data_ff[37:24]),
      .luminance   (req_data_ff[47:38]),
      .view        (view),
      .segs        (segs),
      .dwell       (dwell)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff <= req_tdata;
         req_cmd_ff  <= req_tuser;
      end
      if (step) begin
         rsp_data_ff <= {write_second, write_minute, write_hour, sample_request, dwell,
                         segs.seg3, segs.seg2, segs.seg1, segs.seg0};
         rsp_user_ff <= write_kind;
      end
   end

endmodule

// ===== src/cdmc_csr.sv =====
// Configuration register file of the clock display controller.
module cdmc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cdmc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cdmc_pkg::CSR_DATA_W-1:0]  csr_data,
   output cdmc_pkg::cfg_type                cfg
);

   cdmc_pkg::cfg_type cfg_ff;
   cdmc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cdmc_pkg::CSR_BLINK_TICKS:    cfg_in.blink_ticks    = csr_data[7:0];
            cdmc_pkg::CSR_SAMPLE_TICKS:   cfg_in.sample_ticks   = csr_data[7:0];
            cdmc_pkg::CSR_TIME_PHASE_END: cfg_in.time_phase_end = csr_data;
            cdmc_pkg::CSR_TEMP_PHASE_END: cfg_in.temp_phase_end = csr_data;
            cdmc_pkg::CSR_CYCLE_END:      cfg_in.cycle_end      = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_ticks    <= cdmc_pkg::BLINK_TICKS_RESET;
         cfg_ff.sample_ticks   <= cdmc_pkg::SAMPLE_TICKS_RESET;
         cfg_ff.time_phase_end <= cdmc_pkg::TIME_PHASE_END_RESET;
         cfg_ff.temp_phase_end <= cdmc_pkg::TEMP_PHASE_END_RESET;
         cfg_ff.cycle_end      <= cdmc_pkg::CYCLE_END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/cdmc_ctrl.sv =====
// Controller state: counters, menu, held time, and the tick and key results.
module cdmc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           cmd,
   input  logic [7:0]           rtc_hour,
   input  logic [7:0]           rtc_minute,
   input  logic [7:0]           rtc_second,
   input  cdmc_pkg::cfg_type    cfg,
   output cdmc_pkg::view_type   view,
   output logic                 sample_request,
   output logic [1:0]           write_kind,
   output logic [7:0]           write_hour,
   output logic [7:0]           write_minute,
   output logic [7:0]           write_second
);

   logic [2:0] menu_mode_ff, menu_mode_in;
   logic       blink_on_ff, blink_on_in;
   logic [7:0] blink_count_ff, blink_count_in;
   logic [7:0] sample_count_ff, sample_count_in;
   logic [9:0] rotation_count_ff, rotation_count_in;
   logic       show_temp_ff, show_temp_in;
   logic       show_light_ff, show_light_in;
   logic [7:0] held_hour_ff, held_hour_in;
   logic [7:0] held_minute_ff, held_minute_in;
   logic [7:0] held_second_ff, held_second_in;
   logic [7:0] minute_step;
   logic [8:0] hour_step;
   logic [2:0] menu_next;

   assign view.menu_mode   = menu_mode_ff;
   assign view.blink_on    = blink_on_ff;
   assign view.show_temp   = show_temp_ff;
   assign view.show_light  = show_light_ff;
   assign view.held_hour   = held_hour_ff;
   assign view.held_minute = held_minute_ff;

   // BCD steps of the held minute and hour.
   always_comb begin
      minute_step = (held_minute_ff >= cdmc_pkg::MINUTE_TOP) ? 8'd0 : held_minute_ff + 8'd1;
      if (minute_step[3:0] >= 4'd10) begin
         minute_step = {minute_step[7:4], 4'd0} + 8'h10;
      end
      hour_step = 9'(held_hour_ff) + 9'd1;
      if (hour_step[3:0] >= 4'd10) begin
         hour_step = {1'b0, hour_step[7:4], 4'd0} + 9'h010;
      end
      if (hour_step >= cdmc_pkg::HOUR_LIMIT) begin
         hour_step = 9'd0;
      end
   end

   assign menu_next = menu_mode_ff + 3'd1;

   always_comb begin
      menu_mode_in      = menu_mode_ff;
      blink_on_in       = blink_on_ff;
      blink_count_in    = blink_count_ff;
      sample_count_in   = sample_count_ff;
      rotation_count_in = rotation_count_ff;
      show_temp_in      = show_temp_ff;
      show_light_in     = show_light_ff;
      held_hour_in      = held_hour_ff;
      held_minute_in    = held_minute_ff;
      held_second_in    = held_second_ff;
      sample_request    = 1'b0;
      write_kind        = cdmc_pkg::WRITE_NONE;
      write_hour        = 8'd0;
      write_minute      = 8'd0;
      write_second      = 8'd0;
      unique case (cmd)
         cdmc_pkg::CMD_TICK: begin
            blink_count_in    = blink_count_ff + 8'd1;
            sample_count_in   = sample_count_ff + 8'd1;
            rotation_count_in = rotation_count_ff + 10'd1;
            if (sample_count_in > cfg.sample_ticks) begin
               sample_count_in = 8'd0;
               sample_request  = 1'b1;
            end
            if (blink_count_in == cfg.blink_ticks) begin
               blink_count_in = 8'd0;
               blink_on_in    = !blink_on_ff;
            end
            // Later phases win where the bounds overlap; a count on a bound keeps the flags.
            if (rotation_count_in > 10'd0 && rotation_count_in < cfg.time_phase_end) begin
               show_temp_in  = 1'b0;
               show_light_in = 1'b0;
            end
            if (rotation_count_in > cfg.time_phase_end &&
                rotation_count_in < cfg.temp_phase_end) begin
               show_temp_in  = 1'b1;
               show_light_in = 1'b0;
            end
            if (rotation_count_in > cfg.temp_phase_end && rotation_count_in < cfg.cycle_end) begin
               show_temp_in  = 1'b0;
               show_light_in = 1'b1;
            end
            if (rotation_count_in > cfg.cycle_end) begin
               rotation_count_in = 10'd0;
            end
         end
         cdmc_pkg::CMD_KEY_ONE: begin
            menu_mode_in = menu_next;
            if (menu_next == cdmc_pkg::MENU_WRAP || menu_next == cdmc_pkg::MENU_ROTATE) begin
               menu_mode_in = cdmc_pkg::MENU_ROTATE;
               write_kind   = cdmc_pkg::WRITE_STORE;
               write_hour   = held_hour_ff;
               write_minute = held_minute_ff;
               write_second = held_second_ff;
            end
         end
         cdmc_pkg::CMD_KEY_TWO: begin
            if (menu_mode_ff == cdmc_pkg::MENU_ROTATE || menu_mode_ff == cdmc_pkg::MENU_TIME) begin
               write_kind = cdmc_pkg::WRITE_RESET;
            end else if (menu_mode_ff == cdmc_pkg::MENU_SET_MIN) begin
               held_minute_in = minute_step;
               held_second_in = 8'd0;
            end else if (menu_mode_ff == cdmc_pkg::MENU_SET_HOUR) begin
               held_hour_in   = hour_step[7:0];
               held_second_in = 8'd0;
            end
         end
         cdmc_pkg::CMD_REFRESH: begin
            if (cdmc_pkg::time_shown(view)) begin
               held_hour_in   = rtc_hour;
               held_minute_in = rtc_minute;
               held_second_in = rtc_second;
            end
         end
         default: begin
            menu_mode_in = menu_mode_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         menu_mode_ff      <= cdmc_pkg::MENU_ROTATE;
         blink_on_ff       <= 1'b0;
         blink_count_ff    <= 8'd0;
         sample_count_ff   <= 8'd0;
         rotation_count_ff <= 10'd0;
         show_temp_ff      <= 1'b0;
         show_light_ff     <= 1'b0;
         held_hour_ff      <= 8'd0;
         held_minute_ff    <= 8'd0;
         held_second_ff    <= 8'd0;
      end else if (step) begin
         menu_mode_ff      <= menu_mode_in;
         blink_on_ff       <= blink_on_in;
         blink_count_ff    <= blink_count_in;
         sample_count_ff   <= sample_count_in;
         rotation_count_ff <= rotation_count_in;
         show_temp_ff      <= show_temp_in;
         show_light_ff     <= show_light_in;
         held_hour_ff      <= held_hour_in;
         held_minute_ff    <= held_minute_in;
         held_second_ff    <= held_second_in;
      end
   end

endmodule

// ===== src/cdmc_render.sv =====
// Display formatter: segment bytes and dwell for a refresh item.
module cdmc_render (
   input  logic [1:0]          cmd,
   input  logic [7:0]          rtc_hour,
   input  logic [7:0]          rtc_minute,
   input  logic [13:0]         temperature,
   input  logic [9:0]          luminance,
   input  cdmc_pkg::view_type  view,
   output cdmc_pkg::segs_type  segs,
   output logic [6:0]          dwell
);

   logic [13:0]          temp_sat;
   cdmc_pkg::digits_type temp_dig;
   cdmc_pkg::digits_type lum_dig;
   cdmc_pkg::segs_type   temp_segs;
   cdmc_pkg::segs_type   lum_segs;
   cdmc_pkg::segs_type   time_segs;
   logic [3:0]           t0, t1, t2, t3;
   logic [20:0]          lum_prod;
   logic [4:0]           lum_q50;
   logic                 live_time;

   assign temp_sat = (temperature > cdmc_pkg::TEMP_MAX) ? cdmc_pkg::TEMP_MAX : temperature;
   assign temp_dig = cdmc_pkg::split_decimal(temp_sat);
   assign lum_dig  = cdmc_pkg::split_decimal(14'(luminance));

   always_comb begin
      if (temp_sat >= 14'd10) begin
         temp_segs.seg0 = cdmc_pkg::seg_up_plain(temp_dig.thousands);
         temp_segs.seg1 = cdmc_pkg::seg_up_point(temp_dig.hundreds);
         temp_segs.seg2 = cdmc_pkg::seg_dn_plain(temp_dig.tens);
      end else begin
         temp_segs.seg0 = cdmc_pkg::seg_up_plain(4'd0);
         temp_segs.seg1 = cdmc_pkg::seg_up_point(4'd0);
         temp_segs.seg2 = cdmc_pkg::seg_dn_plain(temp_dig.units);
      end
      temp_segs.seg3 = cdmc_pkg::seg_up_plain(cdmc_pkg::CELSIUS_CODE);
   end

   always_comb begin
      lum_segs.seg0 = cdmc_pkg::seg_up_plain(lum_dig.thousands);
      lum_segs.seg1 = cdmc_pkg::seg_up_plain(lum_dig.hundreds);
      lum_segs.seg2 = cdmc_pkg::seg_dn_plain(lum_dig.tens);
      lum_segs.seg3 = cdmc_pkg::seg_up_point(lum_dig.units);
   end

   // The live time is shown from the clock chip inputs; the setting menus show the held time.
   assign live_time = cdmc_pkg::time_shown(view);

   always_comb begin
      if (live_time) begin
         t0 = rtc_hour[7:4];
         t1 = rtc_hour[3:0];
         t2 = rtc_minute[7:4];
         t3 = rtc_minute[3:0];
      end else begin
         t0 = view.held_hour[7:4];
         t1 = view.held_hour[3:0];
         t2 = view.held_minute[7:4];
         t3 = view.held_minute[3:0];
         if (!view.blink_on && view.menu_mode == cdmc_pkg::MENU_SET_MIN) begin
            t2 = cdmc_pkg::BLANK_CODE;
            t3 = cdmc_pkg::BLANK_CODE;
         end
         if (!view.blink_on && view.menu_mode == cdmc_pkg::MENU_SET_HOUR) begin
            t0 = cdmc_pkg::BLANK_CODE;
            t1 = cdmc_pkg::BLANK_CODE;
         end
      end
      time_segs.seg0 = cdmc_pkg::seg_up_plain(t0);
      time_segs.seg1 = view.blink_on ? cdmc_pkg::seg_up_point(t1) : cdmc_pkg::seg_up_plain(t1);
      time_segs.seg2 = view.blink_on ? cdmc_pkg::seg_dn_point(t2) : cdmc_pkg::seg_dn_plain(t2);
      time_segs.seg3 = cdmc_pkg::seg_up_plain(t3);
   end

   assign lum_prod = 21'(luminance) * cdmc_pkg::RECIP_50;
   assign lum_q50  = lum_prod[cdmc_pkg::SHIFT_50 +: 5];

   always_comb begin
      segs  = {4{cdmc_pkg::SEG_OFF}};
      dwell = 7'd0;
      if (cmd == cdmc_pkg::CMD_REFRESH) begin
         dwell = 7'(lum_q50) * cdmc_pkg::DWELL_MUL;
         unique case (view.menu_mode)
            cdmc_pkg::MENU_ROTATE: begin
               if (view.show_temp) begin
                  segs = temp_segs;
               end else if (view.show_light) begin
                  segs = lum_segs;
               end else begin
                  segs = time_segs;
               end
            end
            cdmc_pkg::MENU_TIME:     segs = time_segs;
            cdmc_pkg::MENU_TEMP:     segs = temp_segs;
            cdmc_pkg::MENU_LIGHT:    segs = lum_segs;
            cdmc_pkg::MENU_SET_MIN:  segs = time_segs;
            cdmc_pkg::MENU_SET_HOUR: segs = time_segs;
            default:                 segs = {4{cdmc_pkg::SEG_OFF}};
         endcase
      end
   end

endmodule

// ===== tb/cdmc_display_checker.sv =====
// Checker for the clock display controller: predicts every result item and compares it.
module cdmc_display_checker
   import cdmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [47:0]            req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [63:0]            rsp_tdata,
   input  logic [1:0]             rsp_tuser,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatch_total,
   output int                     open_results,
   output int                     checked_total
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      FACE_UP_PLAIN,
      FACE_UP_POINT,
      FACE_DN_POINT,
      FACE_DN_PLAIN
   } face_type;

   typedef struct packed {
      logic [7:0]     seg0;
      logic [7:0]     seg1;
      logic [7:0]     seg2;
      logic [7:0]     seg3;
      logic [6:0]     dwell;
      logic           sample_req;
      write_kind_type kind;
      logic [7:0]     w_hour;
      logic [7:0]     w_minute;
      logic [7:0]     w_second;
   } panel_type;

   localparam logic [7:0] UP_PLAIN [0:9] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                             8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
   localparam logic [7:0] UP_POINT [0:9] = '{8'h40, 8'h79, 8'h24, 8'h30, 8'h19,
                                             8'h12, 8'h02, 8'h78, 8'h00, 8'h10};
   localparam logic [7:0] DN_POINT [0:9] = '{8'h40, 8'h4F, 8'h24, 8'h06, 8'h0B,
                                             8'h12, 8'h10, 8'h47, 8'h00, 8'h02};
   localparam logic [7:0] DN_PLAIN [0:9] = '{8'hC0, 8'hCF, 8'hA4, 8'h86, 8'h8B,
                                             8'h92, 8'h90, 8'hC7, 8'h80, 8'h82};
   localparam logic [7:0] SIGN_C = 8'hC6;

   cfg_type    cfg;
   logic [2:0] menu;
   logic       blink_on;
   logic [7:0] blink_cnt;
   logic [7:0] sample_cnt;
   logic [9:0] rot_cnt;
   logic       show_temp;
   logic       show_light;
   logic [7:0] held_hour;
   logic [7:0] held_minute;
   logic [7:0] held_second;

   panel_type panel_due[$];
   panel_type got;
   panel_type want;

   initial begin
      mismatch_total = 0;
      checked_total  = 0;
      open_results   = 0;
   end

   function automatic logic [7:0] glyph(input face_type f, input logic [3:0] code);
      // Only the upright plain face carries the degree sign; any other code past nine is dark.
      if (code == CELSIUS_CODE && f == FACE_UP_PLAIN) return SIGN_C;
      if (code > 4'd9) return SEG_OFF;
      case (f)
         FACE_UP_PLAIN: return UP_PLAIN[code];
         FACE_UP_POINT: return UP_POINT[code];
         FACE_DN_POINT: return DN_POINT[code];
         default:       return DN_PLAIN[code];
      endcase
   endfunction

   function automatic void put_time(input logic [3:0] d0, input logic [3:0] d1,
                                    input logic [3:0] d2, input logic [3:0] d3,
                                    inout panel_type r);
      r.seg0 = glyph(FACE_UP_PLAIN, d0);
      r.seg1 = blink_on ? glyph(FACE_UP_POINT, d1) : glyph(FACE_UP_PLAIN, d1);
      r.seg2 = blink_on ? glyph(FACE_DN_POINT, d2) : glyph(FACE_DN_PLAIN, d2);
      r.seg3 = glyph(FACE_UP_PLAIN, d3);
   endfunction

   function automatic void put_temp(input logic [13:0] raw, inout panel_type r);
      int t;
      int a;
      int b;
      int c;
      t = (raw > TEMP_MAX) ? int'(TEMP_MAX) : int'(raw);
      if (t >= 10) begin
         a = t / 1000;
         b = (t % 1000) / 100;
         c = (t % 100) / 10;
      end else begin
         a = 0;
         b = 0;
         c = t;
      end
      r.seg0 = glyph(FACE_UP_PLAIN, 4'(a));
      r.seg1 = glyph(FACE_UP_POINT, 4'(b));
      r.seg2 = glyph(FACE_DN_PLAIN, 4'(c));
      r.seg3 = glyph(FACE_UP_PLAIN, CELSIUS_CODE);
   endfunction

   function automatic void put_light(input logic [9:0] lum, inout panel_type r);
      int l;
      l = int'(lum);
      r.seg0 = glyph(FACE_UP_PLAIN, 4'(l / 1000));
      r.seg1 = glyph(FACE_UP_PLAIN, 4'((l % 1000) / 100));
      r.seg2 = glyph(FACE_DN_PLAIN, 4'((l % 100) / 10));
      r.seg3 = glyph(FACE_UP_POINT, 4'(l % 10));
   endfunction

   // Advances the controller state by one item and returns the display it produces.
   function automatic panel_type next_panel(input cmd_type op, input logic [47:0] d);
      panel_type  r;
      logic [8:0] v;
      logic [13:0] temp;
      logic [9:0] lum;
      r.seg0       = SEG_OFF;
      r.seg1       = SEG_OFF;
      r.seg2       = SEG_OFF;
      r.seg3       = SEG_OFF;
      r.dwell      = '0;
      r.sample_req = 1'b0;
      r.kind       = WRITE_NONE;
      r.w_hour     = '0;
      r.w_minute   = '0;
      r.w_second   = '0;
      temp = d[37:24];
      lum  = d[47:38];
      case (op)
         CMD_TICK: begin
            blink_cnt  = blink_cnt + 8'd1;
            sample_cnt = sample_cnt + 8'd1;
            rot_cnt    = rot_cnt + 10'd1;
            if (sample_cnt > cfg.sample_ticks) begin
               sample_cnt   = '0;
               r.sample_req = 1'b1;
            end
            if (blink_cnt == cfg.blink_ticks) begin
               blink_cnt = '0;
               blink_on  = !blink_on;
            end
            // A count sitting exactly on a bound keeps whatever the flags were.
            if (rot_cnt > 0 && rot_cnt < cfg.time_phase_end) begin
               show_temp  = 1'b0;
               show_light = 1'b0;
            end
            if (rot_cnt > cfg.time_phase_end && rot_cnt < cfg.temp_phase_end) begin
               show_temp  = 1'b1;
               show_light = 1'b0;
            end
            if (rot_cnt > cfg.temp_phase_end && rot_cnt < cfg.cycle_end) begin
               show_temp  = 1'b0;
               show_light = 1'b1;
            end
            if (rot_cnt > cfg.cycle_end) rot_cnt = '0;
         end
         CMD_KEY_ONE: begin
            menu = menu + 3'd1;
            if (menu == MENU_WRAP || menu == MENU_ROTATE) begin
               menu       = MENU_ROTATE;
               r.kind     = WRITE_STORE;
               r.w_hour   = held_hour;
               r.w_minute = held_minute;
               r.w_second = held_second;
            end
         end
         CMD_KEY_TWO: begin
            if (menu == MENU_ROTATE || menu == MENU_TIME) begin
               r.kind = WRITE_RESET;
            end else if (menu == MENU_SET_MIN) begin
               v = (held_minute >= MINUTE_TOP) ? 9'd0 : {1'b0, held_minute} + 9'd1;
               if (v[3:0] >= 4'd10) v = {v[8:4], 4'd0} + 9'h010;
               held_minute = v[7:0];
               held_second = '0;
            end else if (menu == MENU_SET_HOUR) begin
               v = {1'b0, held_hour} + 9'd1;
               if (v[3:0] >= 4'd10) v = {v[8:4], 4'd0} + 9'h010;
               if (v >= HOUR_LIMIT) v = '0;
               held_hour   = v[7:0];
               held_second = '0;
            end
         end
         default: begin
            if (menu == MENU_TIME ||
                (menu == MENU_ROTATE && !show_temp && !show_light)) begin
               held_hour   = d[7:0];
               held_minute = d[15:8];
               held_second = d[23:16];
               put_time(held_hour[7:4], held_hour[3:0], held_minute[7:4], held_minute[3:0], r);
            end else if (menu == MENU_TEMP || (menu == MENU_ROTATE && show_temp)) begin
               put_temp(temp, r);
            end else if (menu == MENU_LIGHT || menu == MENU_ROTATE) begin
               put_light(lum, r);
            end else if (menu == MENU_SET_MIN) begin
               if (blink_on)
                  put_time(held_hour[7:4], held_hour[3:0], held_minute[7:4], held_minute[3:0], r);
               else
                  put_time(held_hour[7:4], held_hour[3:0], BLANK_CODE, BLANK_CODE, r);
            end else if (menu == MENU_SET_HOUR) begin
               if (blink_on)
                  put_time(held_hour[7:4], held_hour[3:0], held_minute[7:4], held_minute[3:0], r);
               else
                  put_time(BLANK_CODE, BLANK_CODE, held_minute[7:4], held_minute[3:0], r);
            end
            r.dwell = 7'((int'(lum) / 50) * 5);
         end
      endcase
      return r;
   endfunction

   function automatic int field_diff(input string name, input logic [7:0] want_v,
                                     input logic [7:0] got_v);
      if (got_v === want_v) return 0;
      $display("%0t ns: %s differs, expected 0x%02h, actual 0x%02h", $time, name, want_v, got_v);
      return 1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.blink_ticks    = BLINK_TICKS_RESET;
         cfg.sample_ticks   = SAMPLE_TICKS_RESET;
         cfg.time_phase_end = TIME_PHASE_END_RESET;
         cfg.temp_phase_end = TEMP_PHASE_END_RESET;
         cfg.cycle_end      = CYCLE_END_RESET;
         menu        = MENU_ROTATE;
         blink_on    = 1'b0;
         blink_cnt   = '0;
         sample_cnt  = '0;
         rot_cnt     = '0;
         show_temp   = 1'b0;
         show_light  = 1'b0;
         held_hour   = '0;
         held_minute = '0;
         held_second = '0;
         panel_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.seg0       = rsp_tdata[7:0];
            got.seg1       = rsp_tdata[15:8];
            got.seg2       = rsp_tdata[23:16];
            got.seg3       = rsp_tdata[31:24];
            got.dwell      = rsp_tdata[38:32];
            got.sample_req = rsp_tdata[39];
            got.w_hour     = rsp_tdata[47:40];
            got.w_minute   = rsp_tdata[55:48];
            got.w_second   = rsp_tdata[63:56];
            got.kind       = write_kind_type'(rsp_tuser);
            if (panel_due.size() == 0) begin
               $display("%0t ns: result item with nothing expected, actual 0x%h / 0x%h",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_total++;
            end else begin
               want = panel_due.pop_front();
               checked_total++;
               mismatch_total += field_diff("seg_digit0", want.seg0, got.seg0)
                               + field_diff("seg_digit1", want.seg1, got.seg1)
                               + field_diff("seg_digit2", want.seg2, got.seg2)
                               + field_diff("seg_digit3", want.seg3, got.seg3)
                               + field_diff("dwell", 8'(want.dwell), 8'(got.dwell))
                               + field_diff("sample_request", 8'(want.sample_req),
                                            8'(got.sample_req))
                               + field_diff("write_kind", 8'(want.kind), 8'(got.kind))
                               + field_diff("write_hour", want.w_hour, got.w_hour)
                               + field_diff("write_minute", want.w_minute, got.w_minute)
                               + field_diff("write_second", want.w_second, got.w_second);
            end
         end
         if (req_tvalid && req_tready)
            panel_due.push_back(next_panel(cmd_type'(req_tuser), req_tdata));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BLINK_TICKS:    cfg.blink_ticks    = csr_data[7:0];
               CSR_SAMPLE_TICKS:   cfg.sample_ticks   = csr_data[7:0];
               CSR_TIME_PHASE_END: cfg.time_phase_end = csr_data;
               CSR_TEMP_PHASE_END: cfg.temp_phase_end = csr_data;
               CSR_CYCLE_END:      cfg.cycle_end      = csr_data;
               default: ;
            endcase
         end
      end
      open_results <= panel_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the clock display controller testbench: clock, reset, stimulus and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cdmc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_ITEMS = 200;
   // Index beyond the register map; the block must ignore the write.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [47:0]            req_tdata  = '0;
   logic [1:0]             req_tuser  = CMD_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [63:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_BLINK_TICKS;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int mismatch_total;
   int open_results;
   int checked_total;
   int idle_pct = 20;
   int stall_left = 0;
   int items_sent = 0;
   int settings_applied = 0;
   int cycle_count;

   clock_display_mode_controller_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cdmc_display_checker i_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_total (mismatch_total),
      .open_results   (open_results),
      .checked_total  (checked_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side stalls in bursts of random length.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Mostly well-formed BCD, with the odd raw byte so every nibble code turns up.
   function automatic logic [7:0] rand_bcd(input int limit);
      int n;
      if ($urandom_range(0, 99) < 20) return 8'($urandom);
      n = $urandom_range(0, limit - 1);
      return {4'(n / 10), 4'(n % 10)};
   endfunction

   function automatic logic [13:0] rand_temp();
      case ($urandom_range(0, 3))
         0:       return 14'($urandom_range(0, 9));
         1:       return 14'($urandom);
         default: return 14'($urandom_range(0, 9999));
      endcase
   endfunction

   task automatic send_item(input cmd_type op, input logic [7:0] hour, input logic [7:0] minute,
                            input logic [7:0] second, input logic [13:0] temp,
                            input logic [9:0] lum);
      int gap;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {lum, temp, second, minute, hour};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_op(input cmd_type op);
      send_item(op, rand_bcd(24), rand_bcd(60), rand_bcd(60), rand_temp(), 10'($urandom));
   endtask

   task automatic send_random();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      send_op(CMD_TICK);
      else if (pick < 50) send_op(CMD_KEY_ONE);
      else if (pick < 70) send_op(CMD_KEY_TWO);
      else                send_op(CMD_REFRESH);
   endtask

   // Lets every outstanding result drain, then allows for the pipeline depth.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_results != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input int blink, input int sample, input int time_end,
                                input int temp_end, input int cyc_end);
      write_reg(CSR_BLINK_TICKS, blink);
      write_reg(CSR_SAMPLE_TICKS, sample);
      write_reg(CSR_TIME_PHASE_END, time_end);
      write_reg(CSR_TEMP_PHASE_END, temp_end);
      write_reg(CSR_CYCLE_END, cyc_end);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped at the cycle limit with %0d results outstanding.", open_results);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Walk every menu at the reset settings, hitting the digit and wrap corner cases.
      send_op(CMD_TICK);
      send_item(CMD_REFRESH, 8'h23, 8'h59, 8'h59, 14'd9999, 10'd1023);
      send_item(CMD_REFRESH, 8'hFF, 8'hFF, 8'hFF, 14'd0, 10'd0);
      send_op(CMD_KEY_TWO);
      send_op(CMD_KEY_ONE);
      send_item(CMD_REFRESH, 8'h23, 8'h59, 8'h45, 14'd1234, 10'd49);
      send_op(CMD_KEY_TWO);
      send_op(CMD_KEY_ONE);
      send_item(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 14'h3FFF, 10'd50);
      send_item(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 14'd5, 10'd999);
      send_item(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 14'd10, 10'd1000);
      send_op(CMD_KEY_TWO);
      send_op(CMD_KEY_ONE);
      send_item(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 14'd0, 10'd1023);
      send_op(CMD_KEY_TWO);
      send_op(CMD_KEY_ONE);
      send_op(CMD_KEY_TWO);
      send_op(CMD_REFRESH);
      send_op(CMD_KEY_TWO);
      send_op(CMD_KEY_ONE);
      send_op(CMD_KEY_TWO);
      send_op(CMD_REFRESH);
      send_op(CMD_KEY_ONE);
      send_op(CMD_REFRESH);
      settle();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               idle_pct = 20;
               apply_setting(1, 1, 3, 6, 9);
            end
            1: begin
               idle_pct = 30;
               write_reg(CSR_UNMAPPED, 1);
               apply_setting(255, 255, 1023, 1023, 1023);
            end
            2: begin
               idle_pct = 10;
               apply_setting(1, 1, 1, 1, 1);
            end
            3: begin
               idle_pct = 25;
               apply_setting(2, 3, 10, 20, 30);
            end
            default: begin
               // The final phase runs flat out on both sides.
               idle_pct = (phase == 6) ? 0 : 15 * (phase - 3);
               apply_setting($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 40),
                             $urandom_range(1, 40), $urandom_range(1, 40));
            end
         endcase
         repeat (PHASE_ITEMS) send_random();
         settle();
      end

      $display("Covered %0d items under %0d register settings; %0d results compared.",
               items_sent, settings_applied + 1, checked_total);
      if (mismatch_total == 0 && open_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/cdmc_pkg.sv
src/cdmc_csr.sv
src/cdmc_ctrl.sv
src/cdmc_render.sv
src/clock_display_mode_controller_top.sv
tb/cdmc_display_checker.sv
tb/tb_top.sv
